[hw/rtl/image_rotate_bilinear_core_macros.svh]
// assertion macros for the image rotate core checker
// no dependencies
`ifndef IMAGE_ROTATE_BILINEAR_CORE_MACROS_SVH
`define IMAGE_ROTATE_BILINEAR_CORE_MACROS_SVH

// same-cycle implication
`define IRB_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("irb check failed");

// next-cycle implication
`define IRB_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("irb check failed");

`endif

[hw/rtl/irb_pkg.sv]
// shared constants, codes and pipeline types of the image rotate core
// no dependencies
package irb_pkg;

  localparam int DEF_SRC_DIM = 256;
  localparam int DST_DIM = 512;
  localparam int TRIG_FRAC = 14;
  localparam int COORD_FRAC = 8;
  localparam int RND_K = TRIG_FRAC + 1 - COORD_FRAC;

  localparam int DX_W = 12;
  localparam int PROD_W = 28;
  localparam int NUM_W = 28;
  localparam int SQ_W = 21;
  localparam int X_W = SQ_W - COORD_FRAC;
  localparam int WT_W = 2 * COORD_FRAC + 1;
  localparam int ACC_W = 33;
  localparam int QW = 16;

  typedef enum logic [2:0] {
    CFG_COS   = 3'd0,
    CFG_SIN   = 3'd1,
    CFG_SRC_W = 3'd2,
    CFG_SRC_H = 3'd3,
    CFG_DST_W = 3'd4,
    CFG_DST_H = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic            vld;
    logic            query;
    logic [8:0]      col;
    logic [8:0]      row;
    logic [15:0]     value;
    logic            svld;
    logic [SQ_W-1:0] sxq;
    logic [SQ_W-1:0] syq;
  } coord_t;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [8:0]       col;
    logic [8:0]       row;
    logic [ACC_W-1:0] rem;
    logic [WT_W-1:0]  ws;
    logic [QW-1:0]    q;
  } div_t;

endpackage

[hw/rtl/irb_bank.sv]
// one source store bank, one write and one registered read per cycle
// no dependencies
module irb_bank #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [16:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [16:0]   rdata
);

  logic [16:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/irb_map.sv]
// inverse mapping of a destination pixel into source coordinates, three stages
// depends on irb_pkg
module irb_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                item_valid,
  input  logic                op,
  input  logic [8:0]          col,
  input  logic [8:0]          row,
  input  logic [15:0]         sample_value,
  input  logic                sample_valid,
  input  logic signed [15:0]  cos_term,
  input  logic signed [15:0]  sin_term,
  input  logic [8:0]          sw,
  input  logic [8:0]          sh,
  input  logic [9:0]          dw,
  input  logic [9:0]          dh,
  output irb_pkg::coord_t     crd
);
  import irb_pkg::*;

  localparam logic signed [NUM_W-1:0] RND = NUM_W'(1) <<< (RND_K - 1);

  // stage 1
  logic v1, q1, sv1;
  logic [8:0] col1, row1;
  logic [15:0] val1;
  logic signed [DX_W-1:0] dx2, dy2, dx2_next, dy2_next;
  logic signed [9:0] swm1, shm1;

  // stage 2
  logic v2, q2, sv2;
  logic [8:0] col2, row2;
  logic [15:0] val2;
  logic signed [PROD_W-1:0] pcx, psy, psx, pcy;
  logic signed [9:0] swm2, shm2;

  // stage 3
  logic signed [NUM_W-1:0] nx, ny;

  assign dx2_next = {2'b0, col, 1'b0} - {2'b0, dw} + 12'd1;
  assign dy2_next = {2'b0, row, 1'b0} - {2'b0, dh} + 12'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      crd.vld <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      crd.vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1 <= (op == OP_QUERY);
      col1 <= col;
      row1 <= row;
      val1 <= sample_value;
      sv1 <= sample_valid;
      dx2 <= dx2_next;
      dy2 <= dy2_next;
      swm1 <= {1'b0, sw} - 10'd1;
      shm1 <= {1'b0, sh} - 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2 <= q1;
      col2 <= col1;
      row2 <= row1;
      val2 <= val1;
      sv2 <= sv1;
      pcx <= cos_term * dx2;
      psy <= sin_term * dy2;
      psx <= sin_term * dx2;
      pcy <= cos_term * dy2;
      swm2 <= swm1;
      shm2 <= shm1;
    end
  end

  assign nx = pcx - psy + (NUM_W'(swm2) <<< TRIG_FRAC) + RND;
  assign ny = psx + pcy + (NUM_W'(shm2) <<< TRIG_FRAC) + RND;

  always_ff @(posedge clk) begin
    if (adv) begin
      crd.query <= q2;
      crd.col <= col2;
      crd.row <= row2;
      crd.value <= val2;
      crd.svld <= sv2;
      crd.sxq <= SQ_W'(nx >>> RND_K);
      crd.syq <= SQ_W'(ny >>> RND_K);
    end
  end

endmodule

[hw/rtl/irb_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on irb_pkg
module irb_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  irb_pkg::div_t  din,
  output irb_pkg::div_t  dout
);
  import irb_pkg::*;

  div_t st [QW+1];

  assign st[0] = din;
  assign dout = st[QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [ACC_W-1:0] dvs;
    div_t nxt;

    assign dvs = ACC_W'(st[j].ws) << B;

    always_comb begin
      nxt = st[j];
      if (st[j].rem >= dvs) begin
        nxt.rem = st[j].rem - dvs;
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j+1].vld <= 1'b0;
      end else if (adv) begin
        st[j+1] <= nxt;
      end
    end
  end

endmodule

[hw/rtl/image_rotate_bilinear_core.sv]
// image rotate core with bilinear resampling: top level
// depends on irb_pkg, irb_map, irb_bank, irb_div
//
// item channel (item_valid / item_stall): op selects a load, which writes
// sample_value and sample_valid at (col, row) of the source store, or a
// query, which asks for the rotated value at destination (col, row).
// result channel (result_valid / result_stall): one transfer per query,
// none per load, in query order.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
// writes, always ready; write only while no query is in flight.
// throughput: one item per cycle unless a result stall holds the pipe;
// the source store is split in four banks by row and column parity, so
// the four neighbors read in the same cycle.
// a full stall of result_valid holds every stage; item_stall follows it.
// reset clears all valid bits and restores the registers; the store
// contents stay undefined until loaded.
module image_rotate_bilinear_core #(
  parameter int SRC_DIM = irb_pkg::DEF_SRC_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        op,
  input  logic [8:0]  col,
  input  logic [8:0]  row,
  input  logic [15:0] sample_value,
  input  logic        sample_valid,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [8:0]  out_col,
  output logic [8:0]  out_row,
  output logic [15:0] out_value,
  output logic        out_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import irb_pkg::*;

  localparam int HALF = (SRC_DIM + 1) / 2;
  localparam int HW = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int AW = 2 * HW;
  localparam int SRC_CLAMP = (SRC_DIM > 511) ? 511 : SRC_DIM;
  localparam logic [WT_W-1:0] ONE = WT_W'(1) << COORD_FRAC;
  localparam logic [WT_W-1:0] HALF_W = ONE << (COORD_FRAC - 1);
  localparam logic signed [X_W-1:0] XONE = 1;

  logic adv;
  logic signed [15:0] cos_term, sin_term;
  logic [8:0] src_width, src_height, sw, sh;
  logic [9:0] dst_width, dst_height, dw, dh;
  coord_t crd;

  // stage 4
  logic signed [X_W-1:0] x0, y0, x1, y1, swm, shm;
  logic [COORD_FRAC-1:0] fx, fy;
  logic [COORD_FRAC:0] ofx, ofy;
  logic inr, ux0, ux1, uy0, uy1, ld_ok;
  logic [3:0] use_next;
  logic [X_W-1:0] cpar [2];
  logic [X_W-1:0] rpar [2];
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [16:0] rdata [4];
  logic [3:0] we;
  logic v4, xp4, yp4;
  logic [8:0] col4, row4;
  logic [3:0] u4;
  logic [WT_W-1:0] w4 [4];

  // stage 5
  logic v5;
  logic [8:0] col5, row5;
  logic [31:0] prod5 [4];
  logic [WT_W-1:0] wu5 [4];
  logic [31:0] prod_next [4];
  logic [WT_W-1:0] wu_next [4];

  // stage 6
  div_t s6, s6_next, dres;
  logic [WT_W-1:0] wsum;

  assign cfg_ready = 1'b1;
  assign adv = !(result_valid && result_stall);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_term <= 16'sd16384;
      sin_term <= 16'sd0;
      src_width <= 9'd256;
      src_height <= 9'd256;
      dst_width <= 10'd256;
      dst_height <= 10'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COS:   cos_term <= cfg_data;
        CFG_SIN:   sin_term <= cfg_data;
        CFG_SRC_W: src_width <= cfg_data[8:0];
        CFG_SRC_H: src_height <= cfg_data[8:0];
        CFG_DST_W: dst_width <= cfg_data[9:0];
        CFG_DST_H: dst_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign sw = (int'(src_width) > SRC_DIM) ? 9'(SRC_CLAMP) : src_width;
  assign sh = (int'(src_height) > SRC_DIM) ? 9'(SRC_CLAMP) : src_height;
  assign dw = (dst_width > 10'(DST_DIM)) ? 10'(DST_DIM) : dst_width;
  assign dh = (dst_height > 10'(DST_DIM)) ? 10'(DST_DIM) : dst_height;

  irb_map u_map (
    .clk, .rst, .adv, .item_valid, .op, .col, .row, .sample_value, .sample_valid,
    .cos_term, .sin_term, .sw, .sh, .dw, .dh, .crd
  );

  // neighbor geometry
  assign x0 = X_W'($signed(crd.sxq) >>> COORD_FRAC);
  assign y0 = X_W'($signed(crd.syq) >>> COORD_FRAC);
  assign x1 = x0 + XONE;
  assign y1 = y0 + XONE;
  assign fx = crd.sxq[COORD_FRAC-1:0];
  assign fy = crd.syq[COORD_FRAC-1:0];
  assign ofx = (COORD_FRAC+1)'(ONE) - {1'b0, fx};
  assign ofy = (COORD_FRAC+1)'(ONE) - {1'b0, fy};
  assign swm = $signed({{(X_W-9){1'b0}}, sw}) - XONE;
  assign shm = $signed({{(X_W-9){1'b0}}, sh}) - XONE;
  assign inr = (x0 >= -XONE) && (x0 <= swm) && (y0 >= -XONE) && (y0 <= shm);
  assign ux0 = !x0[X_W-1];
  assign ux1 = x0 < swm;
  assign uy0 = !y0[X_W-1];
  assign uy1 = y0 < shm;
  assign use_next = {4{inr}} & {ux1 & uy1, ux0 & uy1, ux1 & uy0, ux0 & uy0};

  assign cpar[0] = x0[0] ? x1 : x0;
  assign cpar[1] = x0[0] ? x0 : x1;
  assign rpar[0] = y0[0] ? y1 : y0;
  assign rpar[1] = y0[0] ? y0 : y1;

  // loads
  assign ld_ok = crd.vld && !crd.query && (int'(crd.col) < SRC_DIM)
                 && (int'(crd.row) < SRC_DIM);
  assign waddr = {HW'({{(X_W-9){1'b0}}, crd.row} >> 1),
                  HW'({{(X_W-9){1'b0}}, crd.col} >> 1)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign raddr[b] = {rpar[b/2][HW:1], cpar[b%2][HW:1]};
    assign we[b] = adv && ld_ok && (crd.row[0] == 1'(b / 2)) && (crd.col[0] == 1'(b % 2));

    irb_bank #(.AW(AW)) u_bank (
      .clk,
      .we(we[b]),
      .waddr,
      .wdata({crd.svld, crd.value}),
      .re(adv),
      .raddr(raddr[b]),
      .rdata(rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      s6.vld <= 1'b0;
    end else if (adv) begin
      v4 <= crd.vld && crd.query;
      v5 <= v4;
      s6.vld <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xp4 <= x0[0];
      yp4 <= y0[0];
      col4 <= crd.col;
      row4 <= crd.row;
      u4 <= use_next;
      w4[0] <= WT_W'(ofx * ofy);
      w4[1] <= WT_W'({1'b0, fx} * ofy);
      w4[2] <= WT_W'(ofx * {1'b0, fy});
      w4[3] <= WT_W'({1'b0, fx} * {1'b0, fy});
    end
  end

  // weighted samples
  for (genvar k = 0; k < 4; k++) begin : g_nb
    logic [1:0] bsel;
    logic [16:0] ent;
    assign bsel = {yp4 ^ 1'(k / 2), xp4 ^ 1'(k % 2)};
    assign ent = rdata[bsel];
    assign wu_next[k] = (u4[k] && ent[16]) ? w4[k] : '0;
    assign prod_next[k] = 32'(wu_next[k] * ent[15:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col5 <= col4;
      row5 <= row4;
      prod5 <= prod_next;
      wu5 <= wu_next;
    end
  end

  assign wsum = wu5[0] + wu5[1] + wu5[2] + wu5[3];

  always_comb begin
    s6_next.vld = v5;
    s6_next.ok = wsum > HALF_W;
    s6_next.col = col5;
    s6_next.row = row5;
    s6_next.ws = wsum;
    s6_next.q = '0;
    s6_next.rem = ACC_W'(prod5[0]) + ACC_W'(prod5[1]) + ACC_W'(prod5[2])
                + ACC_W'(prod5[3]) + ACC_W'(wsum >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6.ok <= s6_next.ok;
      s6.col <= s6_next.col;
      s6.row <= s6_next.row;
      s6.ws <= s6_next.ws;
      s6.q <= s6_next.q;
      s6.rem <= s6_next.rem;
    end
  end

  irb_div u_div (
    .clk, .rst, .adv, .din(s6), .dout(dres)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dres.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_col <= dres.col;
      out_row <= dres.row;
      out_value <= dres.ok ? dres.q : '0;
      out_valid <= dres.ok;
    end
  end

endmodule

[hw/rtl/irb_checker.sv]
// port-level checks of the image rotate core, bound to the top level
// depends on image_rotate_bilinear_core_macros.svh
`include "image_rotate_bilinear_core_macros.svh"

module irb_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [8:0]  out_col,
  input logic [8:0]  out_row,
  input logic [15:0] out_value,
  input logic        out_valid,
  input logic        cfg_ready
);

  `IRB_ASSERT_NXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(out_value) && $stable(out_col) && $stable(out_row) && $stable(out_valid))
  `IRB_ASSERT_IMP(a_blank, clk, rst, result_valid && !out_valid, out_value == 16'd0)
  `IRB_ASSERT_IMP(a_stall, clk, rst, item_stall, result_valid && result_stall && cfg_ready)
  `IRB_ASSERT_IMP(a_reset, clk, rst, $past(rst), !result_valid)

endmodule

bind image_rotate_bilinear_core irb_checker u_irb_checker (.*);
